/* rtl/core/tprp_pkg.sv */
// ============================================================================
// tprp_pkg
// Shared constants and types of the tone pattern recorder and player.
// ============================================================================
package tprp_pkg;

  // Duration store geometry and tick counter width
  localparam int STORE_DEPTH = 4096;
  localparam int TIME_WIDTH  = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  // Field widths of the stream items
  localparam int BTN_W      = 3;
  localparam int POS_W      = 13;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DEB_W      = 16;
  localparam logic [DEB_W-1:0] DEB_RESET = 16'd300;

  // Register index taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;

  // Button codes: bit0 tone, bit1 play, bit2 record
  localparam logic [BTN_W-1:0] BTN_NONE = 3'b000;
  localparam logic [BTN_W-1:0] BTN_TONE = 3'b001;
  localparam logic [BTN_W-1:0] BTN_PLAY = 3'b010;
  localparam logic [BTN_W-1:0] BTN_REC  = 3'b100;

  // Debounced button events
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_TONE    = 3'd1,
    EV_PLAY    = 3'd2,
    EV_REC     = 3'd3,
    EV_RELEASE = 3'd4
  } btn_event_t;

  // Operating modes
  typedef enum logic [4:0] {
    MODE_IDLE      = 5'b00001,
    MODE_TONE      = 5'b00010,
    MODE_REC_PAUSE = 5'b00100,
    MODE_REC_TONE  = 5'b01000,
    MODE_PLAY      = 5'b10000
  } mode_t;

  typedef logic [TIME_WIDTH-1:0] dur_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // One stored duration: tone or pause, and its length in ticks
  typedef struct packed {
    logic is_tone;
    dur_t dur;
  } entry_t;

endpackage

/* rtl/core/tprp_debounce.sv */
// ============================================================================
// tprp_debounce
// Button debouncer: turns level changes into single events with a lockout.
// ============================================================================
module tprp_debounce (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [tprp_pkg::BTN_W-1:0]       buttons,
  input  logic [tprp_pkg::DEB_W-1:0]       debounce_ticks,
  output tprp_pkg::btn_event_t             ev
);

  logic [tprp_pkg::BTN_W-1:0] held_r, held_nxt;
  logic [tprp_pkg::DEB_W-1:0] lockout_r, lockout_nxt;

  // Lockout countdown, otherwise sample a change and classify it
  always_comb begin
    held_nxt    = held_r;
    lockout_nxt = lockout_r;
    ev          = tprp_pkg::EV_NONE;
    if (lockout_r != '0) begin
      lockout_nxt = lockout_r - 1'b1;
    end else if (buttons != held_r) begin
      held_nxt    = buttons;
      lockout_nxt = debounce_ticks;
      case (buttons)
        tprp_pkg::BTN_TONE: ev = tprp_pkg::EV_TONE;
        tprp_pkg::BTN_PLAY: ev = tprp_pkg::EV_PLAY;
        tprp_pkg::BTN_REC:  ev = tprp_pkg::EV_REC;
        tprp_pkg::BTN_NONE: ev = tprp_pkg::EV_RELEASE;
        default:            ev = tprp_pkg::EV_NONE;
      endcase
    end
  end

  // State advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      lockout_r <= '0;
    end else if (step) begin
      held_r    <= held_nxt;
      lockout_r <= lockout_nxt;
    end
  end

endmodule

/* rtl/core/tone_pattern_record_playback.sv */
// ============================================================================
// tone_pattern_record_playback
// Records button-driven tone and pause durations and plays them back.
// ============================================================================
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata[2:0] buttons
//  out_    | out | out_tvalid/out_tready| tdata: tone, rec, play, position
//  cfg_    | in  | APB, pready tied 1   | reg 0 debounce_ticks at 0x0
//
// One item per clock: a result is registered when its item is taken and
// the next item is taken while that result waits. The duration store is a
// single-port-write, dual-read memory that is prefetched every cycle at the
// current and following play entry, so playback can step one entry per item.
// Reset is synchronous; the store is not cleared (the end position marks
// the valid range). out_tready low stalls the input once a result waits.
// ============================================================================
module tone_pattern_record_playback (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tprp_pkg::IN_DATA_W-1:0]      in_tdata,   // [2:0] buttons
  // Result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] tone_request, [1] recording, [2] playing, [15:3] entry_position
  output logic [tprp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tprp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tprp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tprp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam tprp_pkg::idx_t LAST_IDX = tprp_pkg::IDX_W'(tprp_pkg::STORE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [tprp_pkg::DEB_W-1:0] deb_ticks_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r <= tprp_pkg::DEB_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == tprp_pkg::REG_DEBOUNCE)) begin
      deb_ticks_r <= cfg_pwdata[tprp_pkg::DEB_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == tprp_pkg::REG_DEBOUNCE) ?
                      tprp_pkg::CFG_DATA_W'(deb_ticks_r) : '0;

  // --------------------------------------------------------------------------
  // Handshake and output register
  // --------------------------------------------------------------------------
  logic                                step;
  logic                                out_valid_r;
  logic [tprp_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic [tprp_pkg::OUT_DATA_W-1:0]     result;

  assign in_tready  = !out_valid_r || out_tready;
  assign step       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Debouncer
  // --------------------------------------------------------------------------
  tprp_pkg::btn_event_t ev;

  tprp_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .buttons        (in_tdata[tprp_pkg::BTN_W-1:0]),
    .debounce_ticks (deb_ticks_r),
    .ev             (ev)
  );

  // --------------------------------------------------------------------------
  // Duration store with registered reads and write forwarding
  // --------------------------------------------------------------------------
  tprp_pkg::entry_t store_mem [tprp_pkg::STORE_DEPTH];
  tprp_pkg::entry_t rd_a_r, rd_b_r, fwd_data_r;
  logic             fwd_a_r, fwd_b_r;
  tprp_pkg::idx_t   rd_addr_a, rd_addr_b;
  logic             wr_en;
  tprp_pkg::entry_t wr_data;
  tprp_pkg::entry_t cur_ent, nxt_ent;
  tprp_pkg::idx_t   entry_index_r, entry_index_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[entry_index_r] <= wr_data;
    end
    rd_a_r     <= store_mem[rd_addr_a];
    rd_b_r     <= store_mem[rd_addr_b];
    fwd_data_r <= wr_data;
  end

  // A write landing on an address read in the same cycle wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      fwd_a_r <= wr_en && (entry_index_r == rd_addr_a);
      fwd_b_r <= wr_en && (entry_index_r == rd_addr_b);
    end
  end

  assign cur_ent = fwd_a_r ? fwd_data_r : rd_a_r;
  assign nxt_ent = fwd_b_r ? fwd_data_r : rd_b_r;

  // --------------------------------------------------------------------------
  // Mode machine
  // --------------------------------------------------------------------------
  tprp_pkg::mode_t mode_r, mode_nxt;
  tprp_pkg::idx_t  end_pos_r, end_pos_nxt;
  tprp_pkg::dur_t  elapsed_r, elapsed_nxt;
  logic            have_rec_r, have_rec_nxt;
  tprp_pkg::dur_t  el_inc;
  tprp_pkg::idx_t  idx_inc;
  logic            advanced;
  logic            tone_req;

  assign el_inc  = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign idx_inc = entry_index_r + 1'b1;

  always_comb begin
    mode_nxt        = mode_r;
    entry_index_nxt = entry_index_r;
    end_pos_nxt     = end_pos_r;
    elapsed_nxt     = elapsed_r;
    have_rec_nxt    = have_rec_r;
    wr_en           = 1'b0;
    wr_data.is_tone = 1'b0;
    wr_data.dur     = el_inc;
    advanced        = 1'b0;
    if (step) begin
      case (mode_r)
        tprp_pkg::MODE_IDLE: begin
          if (ev == tprp_pkg::EV_TONE) begin
            mode_nxt = tprp_pkg::MODE_TONE;
          end else if (ev == tprp_pkg::EV_REC) begin
            entry_index_nxt = '0;
            elapsed_nxt     = '0;
            mode_nxt        = tprp_pkg::MODE_REC_PAUSE;
          end else if ((ev == tprp_pkg::EV_PLAY) && have_rec_r) begin
            entry_index_nxt = '0;
            elapsed_nxt     = '0;
            mode_nxt        = (end_pos_r == '0) ? tprp_pkg::MODE_IDLE
                                                : tprp_pkg::MODE_PLAY;
          end
        end
        tprp_pkg::MODE_TONE: begin
          if (ev == tprp_pkg::EV_RELEASE) begin
            mode_nxt = tprp_pkg::MODE_IDLE;
          end
        end
        tprp_pkg::MODE_REC_PAUSE: begin
          elapsed_nxt = el_inc;
          if ((ev == tprp_pkg::EV_TONE) || (ev == tprp_pkg::EV_REC)) begin
            wr_en           = 1'b1;
            entry_index_nxt = idx_inc;
            // Store full or record pressed: the end sits right after
            if ((idx_inc == LAST_IDX) || (ev == tprp_pkg::EV_REC)) begin
              end_pos_nxt  = idx_inc;
              have_rec_nxt = 1'b1;
              mode_nxt     = tprp_pkg::MODE_IDLE;
            end else begin
              elapsed_nxt = '0;
              mode_nxt    = tprp_pkg::MODE_REC_TONE;
            end
          end
        end
        tprp_pkg::MODE_REC_TONE: begin
          elapsed_nxt = el_inc;
          if (ev == tprp_pkg::EV_RELEASE) begin
            wr_en           = 1'b1;
            wr_data.is_tone = 1'b1;
            entry_index_nxt = idx_inc;
            if (idx_inc == LAST_IDX) begin
              end_pos_nxt  = idx_inc;
              have_rec_nxt = 1'b1;
              mode_nxt     = tprp_pkg::MODE_IDLE;
            end else begin
              elapsed_nxt = '0;
              mode_nxt    = tprp_pkg::MODE_REC_PAUSE;
            end
          end
        end
        tprp_pkg::MODE_PLAY: begin
          elapsed_nxt = el_inc;
          if (el_inc > cur_ent.dur) begin
            advanced        = 1'b1;
            entry_index_nxt = idx_inc;
            elapsed_nxt     = '0;
            if (idx_inc == end_pos_r) begin
              mode_nxt = tprp_pkg::MODE_IDLE;
            end
          end
          if (ev == tprp_pkg::EV_PLAY) begin
            mode_nxt = tprp_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = tprp_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  // Prefetch the current and following entry of the next state
  assign rd_addr_a = (mode_nxt == tprp_pkg::MODE_PLAY) ? entry_index_nxt : '0;
  assign rd_addr_b = rd_addr_a + 1'b1;

  // Result fields after the update
  always_comb begin
    case (mode_nxt)
      tprp_pkg::MODE_TONE,
      tprp_pkg::MODE_REC_TONE: tone_req = 1'b1;
      tprp_pkg::MODE_PLAY:     tone_req = advanced ? nxt_ent.is_tone
                                                   : cur_ent.is_tone;
      default:                 tone_req = 1'b0;
    endcase
    result[0]  = tone_req;
    result[1]  = (mode_nxt == tprp_pkg::MODE_REC_PAUSE) ||
                 (mode_nxt == tprp_pkg::MODE_REC_TONE);
    result[2]  = (mode_nxt == tprp_pkg::MODE_PLAY);
    result[15:3] = tprp_pkg::POS_W'(entry_index_nxt);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= tprp_pkg::MODE_IDLE;
      entry_index_r <= '0;
      elapsed_r     <= '0;
      have_rec_r    <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      entry_index_r <= entry_index_nxt;
      elapsed_r     <= elapsed_nxt;
      have_rec_r    <= have_rec_nxt;
    end
  end

  // End position is only read once a recording exists
  always_ff @(posedge clk) begin
    end_pos_r <= end_pos_nxt;
  end

endmodule
